>>> rtl/hfa_pkg.sv
package hfa_pkg;

  localparam int POOL_CHUNKS = 1024;
  localparam int CHUNK_BYTES = 32;
  localparam int BUCKETS     = 11;
  localparam int HDR_BYTES   = 4;
  localparam int Q_DEPTH     = 2;

  localparam int REQ_W  = 16;
  localparam int STS_W  = 2;
  localparam int IDX_W  = $clog2(POOL_CHUNKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int BI_W   = $clog2(BUCKETS);
  localparam int NEED_W = $clog2(CNT_W + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FREED = 2'd2
  } status_t;

  // classified item handed from the front to the engine
  typedef struct packed {
    logic              is_free;
    logic              oversize;
    logic [CNT_W-1:0]  chunks;
    logic [NEED_W-1:0] need;
    logic [IDX_W-1:0]  blk;
  } req_t;

  // per-chunk header record
  typedef struct packed {
    logic [IDX_W-1:0] pprev;
    logic [IDX_W-1:0] pnext;
    logic [CNT_W-1:0] chunks;
    logic             in_use;
    logic             is_head;
    logic [IDX_W-1:0] lprev;
    logic [IDX_W-1:0] lnext;
    logic             lp_ok;
    logic             ln_ok;
  } node_t;

  // min(floor(log2 n), BUCKETS-1)
  function automatic logic [BI_W-1:0] bucket_of(input logic [CNT_W-1:0] n);
    logic [BI_W-1:0] b;
    b = '0;
    for (int i = 1; i < BUCKETS; i++) begin
      if (i < CNT_W) begin
        if ((n >> i) != '0) b = BI_W'(i);
      end
    end
    return b;
  endfunction

  localparam logic [BUCKETS-1:0] BKT_INIT =
    BUCKETS'(1) << bucket_of(CNT_W'(POOL_CHUNKS));

endpackage

>>> rtl/hfa_front.sv
module hfa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [hfa_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [hfa_pkg::IDX_W-1:0]   in_block_index,
  output logic                        req_valid,
  input  logic                        req_ready,
  output hfa_pkg::req_t               req
);
  import hfa_pkg::*;

  localparam int BYTE_W = REQ_W + 1;
  localparam int SUM_W  = REQ_W + 2;

  logic [BYTE_W-1:0] bytes;
  logic [SUM_W-1:0]  raw_chunks;
  logic [CNT_W-1:0]  chunks;
  logic [CNT_W-1:0]  cm1;
  logic [NEED_W-1:0] need;
  logic              oversize;
  req_t              cls;
  logic              valid_r;
  req_t              item_r;

  always_comb begin
    bytes      = BYTE_W'(in_request_bytes) + BYTE_W'(HDR_BYTES);
    oversize   = 32'(bytes) > 32'(POOL_CHUNKS * CHUNK_BYTES);
    raw_chunks = (SUM_W'(bytes) + SUM_W'(CHUNK_BYTES - 1)) >> $clog2(CHUNK_BYTES);
    chunks     = CNT_W'(raw_chunks);
    // ceil(log2 c) = bit length of c-1
    cm1  = chunks - CNT_W'(1);
    need = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (cm1[i]) need = NEED_W'(i + 1);
    end
    if (chunks <= CNT_W'(1)) need = '0;
    cls.is_free  = (in_action == ACT_FREE);
    cls.oversize = oversize;
    cls.chunks   = chunks;
    cls.need     = need;
    cls.blk      = in_block_index;
  end

  assign in_ready  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
        item_r  <= cls;
      end else if (req_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/hfa_fifo.sv
module hfa_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hfa_pkg::req_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hfa_pkg::req_t pop_item
);
  import hfa_pkg::*;

  localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  req_t            q_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != QC_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = q_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        q_r[wp_r] <= push_item;
        wp_r <= (wp_r == QP_W'(Q_DEPTH - 1)) ? '0 : wp_r + QP_W'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == QP_W'(Q_DEPTH - 1)) ? '0 : rp_r + QP_W'(1);
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + QC_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QC_W'(1);
    end
  end

endmodule

>>> rtl/hfa_back.sv
module hfa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  hfa_pkg::req_t               req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hfa_pkg::STS_W-1:0]   out_status,
  output logic [hfa_pkg::IDX_W-1:0]   out_grant_index
);
  import hfa_pkg::*;

  localparam int END_W = CNT_W + 1;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_MRD, S_MOP, S_DONE,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6,
    S_F1, S_F2, S_F3, S_F4, S_F6, S_F7, S_F8, S_F9,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_U1, S_U2, S_U3, S_P0, S_P1
  } state_t;

  typedef enum logic [3:0] {
    OP_READ, OP_LNEXT, OP_LPREV, OP_PPREV, OP_CLRLINK, OP_PUSHX,
    OP_FREE, OP_ALLOC, OP_NEWBLK, OP_MERGEL, OP_KILL
  } op_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    op_t              op;
    logic [IDX_W-1:0] v;
    logic             f;
    logic [CNT_W-1:0] cv;
    state_t           ret;
  } mreq_t;

  function automatic mreq_t mk(input logic [IDX_W-1:0] a, input op_t o,
                               input logic [IDX_W-1:0] v, input logic f,
                               input logic [CNT_W-1:0] cv, input state_t r);
    mreq_t m;
    m.addr = a;
    m.op   = o;
    m.v    = v;
    m.f    = f;
    m.cv   = cv;
    m.ret  = r;
    return m;
  endfunction

  node_t node_mem [POOL_CHUNKS];
  node_t node_q_r;
  node_t rec_r;

  state_t            state_r;
  mreq_t             mc_r;
  req_t              item_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [BUCKETS-1:0] bkt_ne_r;
  logic [IDX_W-1:0]  bkt_head_r [BUCKETS];

  logic [BI_W-1:0]   b_r, sb_r;
  logic [IDX_W-1:0]  h_r, oldnext_r, sx_r, hh_r, uprev_r, unext_r;
  logic [IDX_W-1:0]  lprev_r, cur_r, ml_r, mr_r, rpnext_r;
  logic [CNT_W-1:0]  have_r, xch_r, lch_r, ns_r;
  logic [END_W-1:0]  mend_r;
  logic              ulp_r, uln_r;
  state_t            sret_r, mret_r;

  logic [STS_W-1:0]  res_status_r, out_status_r;
  logic [IDX_W-1:0]  res_grant_r, out_grant_r;
  logic              out_valid_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  node_t             wr_data;
  node_t             clr_node;

  logic              fnd;
  logic [BI_W-1:0]   fb;
  logic [CNT_W-1:0]  rem;
  logic [IDX_W-1:0]  nidx;
  logic [END_W-1:0]  aend, fend;
  logic              heads_ok;

  // first non-empty bucket at or above the needed one
  always_comb begin
    fnd = 1'b0;
    fb  = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (bkt_ne_r[i] && i >= int'(item_r.need)) begin
        fnd = 1'b1;
        fb  = BI_W'(i);
      end
    end
  end

  always_comb begin
    rem  = have_r - item_r.chunks;
    nidx = IDX_W'(h_r + item_r.chunks);
    aend = END_W'(h_r) + END_W'(have_r);
    fend = END_W'(cur_r) + END_W'(rec_r.chunks);
  end

  always_comb begin
    clr_node         = '0;
    if (clr_cnt_r == '0) begin
      clr_node.chunks  = CNT_W'(POOL_CHUNKS);
      clr_node.is_head = 1'b1;
    end
    wr_en   = 1'b0;
    wr_addr = mc_r.addr;
    wr_data = node_q_r;
    if (state_r == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = clr_node;
    end else if (state_r == S_MOP) begin
      wr_en = (mc_r.op != OP_READ);
      unique case (mc_r.op)
        OP_READ: ;
        OP_LNEXT: begin
          wr_data.lnext = mc_r.v;
          wr_data.ln_ok = mc_r.f;
        end
        OP_LPREV: begin
          wr_data.lprev = mc_r.v;
          wr_data.lp_ok = mc_r.f;
        end
        OP_PPREV:   wr_data.pprev = mc_r.v;
        OP_CLRLINK: begin
          wr_data.lp_ok = 1'b0;
          wr_data.ln_ok = 1'b0;
        end
        OP_PUSHX: begin
          wr_data.lp_ok = 1'b0;
          wr_data.lnext = mc_r.v;
          wr_data.ln_ok = mc_r.f;
        end
        OP_FREE: wr_data.in_use = 1'b0;
        OP_ALLOC: begin
          wr_data.chunks = mc_r.cv;
          wr_data.in_use = 1'b1;
          if (mc_r.f) wr_data.pnext = mc_r.v;
        end
        OP_NEWBLK: begin
          wr_data         = '0;
          wr_data.pprev   = mc_r.v;
          wr_data.pnext   = oldnext_r;
          wr_data.chunks  = mc_r.cv;
          wr_data.is_head = 1'b1;
        end
        OP_MERGEL: begin
          wr_data.pnext  = mc_r.v;
          wr_data.chunks = mc_r.cv;
        end
        OP_KILL: wr_data.is_head = 1'b0;
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    node_q_r <= node_mem[mc_r.addr];
    if (wr_en) node_mem[wr_addr] <= wr_data;
  end

  assign req_ready       = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_grant_index = out_grant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      bkt_ne_r    <= BKT_INIT;
      out_valid_r <= 1'b0;
      mc_r        <= mk('0, OP_READ, '0, 1'b0, '0, S_IDLE);
      for (int i = 0; i < BUCKETS; i++) bkt_head_r[i] <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + IDX_W'(1);
          if (clr_cnt_r == IDX_W'(POOL_CHUNKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            item_r <= req;
            if (req.is_free) begin
              mc_r    <= mk(req.blk, OP_READ, '0, 1'b0, '0, S_F1);
              state_r <= S_MRD;
            end else begin
              state_r <= S_A0;
            end
          end
        end
        S_MRD: state_r <= S_MOP;
        S_MOP: begin
          if (mc_r.op == OP_READ) rec_r <= node_q_r;
          state_r <= mc_r.ret;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_grant_r  <= res_grant_r;
            state_r      <= S_IDLE;
          end
        end
        // ---------------- allocate
        S_A0: begin
          if (item_r.oversize || !fnd) begin
            res_status_r <= ST_NOFIT;
            res_grant_r  <= '0;
            state_r      <= S_DONE;
          end else begin
            b_r     <= fb;
            h_r     <= bkt_head_r[fb];
            mc_r    <= mk(bkt_head_r[fb], OP_READ, '0, 1'b0, '0, S_A1);
            state_r <= S_MRD;
          end
        end
        S_A1: begin
          if (rec_r.chunks < item_r.chunks) begin
            res_status_r <= ST_NOFIT;
            res_grant_r  <= '0;
            state_r      <= S_DONE;
          end else begin
            have_r    <= rec_r.chunks;
            oldnext_r <= rec_r.pnext;
            sx_r      <= h_r;
            sb_r      <= b_r;
            sret_r    <= S_A2;
            mc_r      <= mk(h_r, OP_READ, '0, 1'b0, '0, S_U1);
            state_r   <= S_MRD;
          end
        end
        S_A2: begin
          mc_r    <= mk(h_r, OP_ALLOC, nidx, rem != '0, item_r.chunks, S_A3);
          state_r <= S_MRD;
        end
        S_A3: begin
          if (rem == '0) begin
            res_status_r <= ST_ALLOC;
            res_grant_r  <= h_r;
            state_r      <= S_DONE;
          end else begin
            mc_r    <= mk(nidx, OP_NEWBLK, h_r, 1'b0, rem, S_A4);
            state_r <= S_MRD;
          end
        end
        S_A4: begin
          if (aend < END_W'(POOL_CHUNKS)) begin
            mc_r    <= mk(IDX_W'(aend), OP_PPREV, nidx, 1'b0, '0, S_A5);
            state_r <= S_MRD;
          end else begin
            state_r <= S_A5;
          end
        end
        S_A5: begin
          sx_r    <= nidx;
          sb_r    <= bucket_of(rem);
          sret_r  <= S_A6;
          state_r <= S_P0;
        end
        S_A6: begin
          res_status_r <= ST_ALLOC;
          res_grant_r  <= h_r;
          state_r      <= S_DONE;
        end
        // ---------------- free
        S_F1: begin
          if (!rec_r.is_head || !rec_r.in_use ||
              CNT_W'(item_r.blk) >= CNT_W'(POOL_CHUNKS)) begin
            state_r <= S_F9;
          end else begin
            lprev_r <= rec_r.pprev;
            xch_r   <= rec_r.chunks;
            mc_r    <= mk(item_r.blk, OP_FREE, '0, 1'b0, '0, S_F2);
            state_r <= S_MRD;
          end
        end
        S_F2: begin
          sx_r    <= item_r.blk;
          sb_r    <= bucket_of(xch_r);
          sret_r  <= S_F3;
          state_r <= S_P0;
        end
        S_F3: begin
          cur_r <= item_r.blk;
          if (item_r.blk != '0) begin
            mc_r    <= mk(lprev_r, OP_READ, '0, 1'b0, '0, S_F4);
            state_r <= S_MRD;
          end else begin
            state_r <= S_F6;
          end
        end
        S_F4: begin
          if (rec_r.is_head && !rec_r.in_use) begin
            cur_r   <= lprev_r;
            ml_r    <= lprev_r;
            mr_r    <= item_r.blk;
            mret_r  <= S_F6;
            state_r <= S_M0;
          end else begin
            state_r <= S_F6;
          end
        end
        S_F6: begin
          mc_r    <= mk(cur_r, OP_READ, '0, 1'b0, '0, S_F7);
          state_r <= S_MRD;
        end
        S_F7: begin
          if (fend < END_W'(POOL_CHUNKS)) begin
            mr_r    <= IDX_W'(fend);
            mc_r    <= mk(IDX_W'(fend), OP_READ, '0, 1'b0, '0, S_F8);
            state_r <= S_MRD;
          end else begin
            state_r <= S_F9;
          end
        end
        S_F8: begin
          if (rec_r.is_head && !rec_r.in_use) begin
            ml_r    <= cur_r;
            mret_r  <= S_F9;
            state_r <= S_M0;
          end else begin
            state_r <= S_F9;
          end
        end
        S_F9: begin
          res_status_r <= ST_FREED;
          res_grant_r  <= '0;
          state_r      <= S_DONE;
        end
        // ---------------- merge ml_r (left) with mr_r (right)
        S_M0: begin
          mc_r    <= mk(ml_r, OP_READ, '0, 1'b0, '0, S_M1);
          state_r <= S_MRD;
        end
        S_M1: begin
          lch_r   <= rec_r.chunks;
          mc_r    <= mk(mr_r, OP_READ, '0, 1'b0, '0, S_M2);
          state_r <= S_MRD;
        end
        S_M2: begin
          rpnext_r <= rec_r.pnext;
          ns_r     <= CNT_W'(lch_r + rec_r.chunks);
          mend_r   <= END_W'(mr_r) + END_W'(rec_r.chunks);
          sx_r     <= mr_r;
          sb_r     <= bucket_of(rec_r.chunks);
          sret_r   <= S_M3;
          mc_r     <= mk(mr_r, OP_READ, '0, 1'b0, '0, S_U1);
          state_r  <= S_MRD;
        end
        S_M3: begin
          mc_r    <= mk(ml_r, OP_MERGEL, rpnext_r, 1'b0, ns_r, S_M4);
          state_r <= S_MRD;
        end
        S_M4: begin
          mc_r    <= mk(mr_r, OP_KILL, '0, 1'b0, '0, S_M5);
          state_r <= S_MRD;
        end
        S_M5: begin
          if (mend_r < END_W'(POOL_CHUNKS)) begin
            mc_r    <= mk(IDX_W'(mend_r), OP_PPREV, ml_r, 1'b0, '0, S_M6);
            state_r <= S_MRD;
          end else begin
            state_r <= S_M6;
          end
        end
        S_M6: begin
          if (bucket_of(ns_r) != bucket_of(lch_r)) begin
            sx_r    <= ml_r;
            sb_r    <= bucket_of(lch_r);
            sret_r  <= S_M7;
            mc_r    <= mk(ml_r, OP_READ, '0, 1'b0, '0, S_U1);
            state_r <= S_MRD;
          end else begin
            state_r <= mret_r;
          end
        end
        S_M7: begin
          sx_r    <= ml_r;
          sb_r    <= bucket_of(ns_r);
          sret_r  <= mret_r;
          state_r <= S_P0;
        end
        // ---------------- unlink sx_r from bucket sb_r (record in rec_r)
        S_U1: begin
          uprev_r <= rec_r.lprev;
          unext_r <= rec_r.lnext;
          ulp_r   <= rec_r.lp_ok;
          uln_r   <= rec_r.ln_ok;
          if (!rec_r.lp_ok) begin
            if (rec_r.ln_ok) begin
              bkt_head_r[sb_r] <= rec_r.lnext;
            end else begin
              bkt_ne_r[sb_r]   <= 1'b0;
              bkt_head_r[sb_r] <= '0;
            end
            state_r <= S_U2;
          end else begin
            mc_r    <= mk(rec_r.lprev, OP_LNEXT, rec_r.lnext, rec_r.ln_ok, '0, S_U2);
            state_r <= S_MRD;
          end
        end
        S_U2: begin
          if (uln_r) begin
            mc_r    <= mk(unext_r, OP_LPREV, uprev_r, ulp_r, '0, S_U3);
            state_r <= S_MRD;
          end else begin
            state_r <= S_U3;
          end
        end
        S_U3: begin
          mc_r    <= mk(sx_r, OP_CLRLINK, '0, 1'b0, '0, sret_r);
          state_r <= S_MRD;
        end
        // ---------------- push sx_r at the head of bucket sb_r
        S_P0: begin
          if (bkt_ne_r[sb_r]) begin
            hh_r <= bkt_head_r[sb_r];
            mc_r <= mk(sx_r, OP_PUSHX, bkt_head_r[sb_r], 1'b1, '0, S_P1);
          end else begin
            bkt_ne_r[sb_r] <= 1'b1;
            mc_r <= mk(sx_r, OP_PUSHX, '0, 1'b0, '0, sret_r);
          end
          bkt_head_r[sb_r] <= sx_r;
          state_r <= S_MRD;
        end
        S_P1: begin
          mc_r    <= mk(hh_r, OP_LPREV, sx_r, 1'b1, '0, sret_r);
          state_r <= S_MRD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an empty bucket always has its head pointer cleared
  always_comb begin
    heads_ok = 1'b1;
    for (int i = 0; i < BUCKETS; i++) begin
      if (!bkt_ne_r[i] && bkt_head_r[i] != '0) heads_ok = 1'b0;
    end
  end

  a_head_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> heads_ok)
    else $error("empty bucket with nonzero head");

  a_rose_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !out_valid_r)
    else $error("result during clearing pass");

  a_mem_call: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MRD |=> state_r == S_MOP)
    else $error("table access sequence broken");

endmodule

>>> rtl/half_fit_allocator_core.sv
// Half-fit allocator over a pool of chunks. Each item either allocates (request_bytes plus a
// 4-byte header, rounded up to chunks) or frees a block by its header chunk index; each item
// gives exactly one result. After reset a clearing pass writes all POOL_CHUNKS (1024) headers
// before the engine takes the first item. Items are classified up front and queued; the engine
// then works on one item at a time against a single-port header table. An allocate can fail;
// a free can be ignored or can merge with both neighbors.
module half_fit_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [hfa_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [hfa_pkg::IDX_W-1:0]   in_block_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hfa_pkg::STS_W-1:0]   out_status,
  output logic [hfa_pkg::IDX_W-1:0]   out_grant_index
);
  import hfa_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_item, b_item;

  hfa_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_block_index   (in_block_index),
    .req_valid        (f_valid),
    .req_ready        (f_ready),
    .req              (f_item)
  );

  hfa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  hfa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (b_valid),
    .req_ready       (b_ready),
    .req             (b_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_grant_index (out_grant_index)
  );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hfa_pkg::*;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] grant;
  } alloc_result_t;

  // predicts the allocator and holds the results still owed by the block
  class alloc_scoreboard;
    int               pprev[POOL_CHUNKS];
    int               pnext[POOL_CHUNKS];
    int               csize[POOL_CHUNKS];
    bit               used[POOL_CHUNKS];
    bit               hdr[POOL_CHUNKS];
    int               lprev[POOL_CHUNKS];
    int               lnext[POOL_CHUNKS];
    bit               lpv[POOL_CHUNKS];
    bit               lnv[POOL_CHUNKS];
    int               head[BUCKETS];
    bit [BUCKETS-1:0] nonempty;
    alloc_result_t    owed[$];
    int               live[$];
    int               errors;

    function new();
      for (int i = 0; i < POOL_CHUNKS; i++) begin
        pprev[i] = 0; pnext[i] = 0; csize[i] = 0; used[i] = 0; hdr[i] = 0;
        lprev[i] = 0; lnext[i] = 0; lpv[i] = 0; lnv[i] = 0;
      end
      for (int b = 0; b < BUCKETS; b++) head[b] = 0;
      nonempty = '0;
      errors = 0;
      csize[0] = POOL_CHUNKS;
      hdr[0] = 1;
      push_blk(size_bucket(POOL_CHUNKS), 0);
    endfunction

    function int size_bucket(int n);
      int b;
      b = 0;
      while (b + 1 < BUCKETS && (n >> (b + 1)) != 0) b++;
      return b;
    endfunction

    function void push_blk(int b, int x);
      lpv[x] = 0;
      if (nonempty[b]) begin
        lnext[x] = head[b];
        lnv[x] = 1;
        lprev[head[b]] = x;
        lpv[head[b]] = 1;
      end else begin
        lnv[x] = 0;
        nonempty[b] = 1;
      end
      head[b] = x;
    endfunction

    function void unlink_blk(int b, int x);
      if (lpv[x]) begin
        lnext[lprev[x]] = lnext[x];
        lnv[lprev[x]] = lnv[x];
      end else if (lnv[x]) begin
        head[b] = lnext[x];
      end else begin
        nonempty[b] = 0;
        head[b] = 0;
      end
      if (lnv[x]) begin
        lprev[lnext[x]] = lprev[x];
        lpv[lnext[x]] = lpv[x];
      end
      lpv[x] = 0;
      lnv[x] = 0;
    endfunction

    function void join_blks(int l, int r);
      int lb, rb, stop, ns, nb;
      lb = size_bucket(csize[l]);
      rb = size_bucket(csize[r]);
      stop = r + csize[r];
      ns = csize[l] + csize[r];
      unlink_blk(rb, r);
      pnext[l] = pnext[r];
      if (stop < POOL_CHUNKS) pprev[stop] = l;
      csize[l] = ns;
      hdr[r] = 0;
      nb = size_bucket(ns);
      if (nb != lb) begin
        unlink_blk(lb, l);
        push_blk(nb, l);
      end
    endfunction

    function alloc_result_t predict(bit act, int req, int bi);
      alloc_result_t r;
      int bytes, c, need, b, h, have, rem, n, cur, stop, l;
      r.status = ST_NOFIT;
      r.grant = '0;
      if (act == ACT_ALLOC) begin
        bytes = req + HDR_BYTES;
        if (bytes > POOL_CHUNKS * CHUNK_BYTES) return r;
        c = (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
        need = 0;
        while ((1 << need) < c) need++;
        b = need;
        while (b < BUCKETS && !nonempty[b]) b++;
        if (b >= BUCKETS) return r;
        h = head[b];
        have = csize[h];
        if (have < c) return r;
        rem = have - c;
        unlink_blk(b, h);
        csize[h] = c;
        if (rem > 0) begin
          n = h + c;
          stop = h + have;
          csize[n] = rem;
          used[n] = 0;
          hdr[n] = 1;
          pprev[n] = h;
          pnext[n] = pnext[h];
          pnext[h] = n;
          if (stop < POOL_CHUNKS) pprev[stop] = n;
          push_blk(size_bucket(rem), n);
        end
        used[h] = 1;
        live.push_back(h);
        r.status = ST_ALLOC;
        r.grant = h[IDX_W-1:0];
        return r;
      end
      r.status = ST_FREED;
      if (!hdr[bi] || !used[bi]) return r;
      foreach (live[i]) begin
        if (live[i] == bi) begin
          live.delete(i);
          break;
        end
      end
      cur = bi;
      used[bi] = 0;
      push_blk(size_bucket(csize[bi]), bi);
      if (bi != 0) begin
        l = pprev[bi];
        if (hdr[l] && !used[l]) begin
          join_blks(l, bi);
          cur = l;
        end
      end
      stop = cur + csize[cur];
      if (stop < POOL_CHUNKS && hdr[stop] && !used[stop]) join_blks(cur, stop);
      return r;
    endfunction

    function void note_item(bit act, int req, int bi);
      owed.push_back(predict(act, req, bi));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [STS_W-1:0] sts, logic [IDX_W-1:0] gi);
      alloc_result_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result status=%0d grant=%0d", sts, gi));
        return;
      end
      e = owed.pop_front();
      if (sts !== e.status)
        report($sformatf("status got %0d want %0d", sts, e.status));
      if (gi !== e.grant)
        report($sformatf("grant_index got %0d want %0d", gi, e.grant));
    endtask
  endclass

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  logic             in_action = 0;
  logic [REQ_W-1:0] in_request_bytes = '0;
  logic [IDX_W-1:0] in_block_index = '0;
  logic             out_valid;
  logic             out_ready = 0;
  logic [STS_W-1:0] out_status;
  logic [IDX_W-1:0] out_grant_index;

  alloc_scoreboard sb = new();
  bit              hold_req = 0;
  bit              calm = 0;

  half_fit_allocator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_grant_index  (out_grant_index)
  );

  always #10 clk = ~clk;

  // sampled at the falling edge, accepted at the next rising edge
  task automatic send_item(bit act, int req, int bi);
    in_valid <= 1'b1;
    in_action <= act;
    in_request_bytes <= req[REQ_W-1:0];
    in_block_index <= bi[IDX_W-1:0];
    do @(negedge clk); while (!in_ready);
    sb.note_item(act, req, bi);
    @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int sel;
    int req;
    sel = $urandom_range(0, 99);
    if (sb.live.size() < 4 || (sb.live.size() < 60 && sel < 50)) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) req = $urandom_range(0, 200);
      else if (sel < 90) req = $urandom_range(0, 2000);
      else if (sel < 98) req = $urandom_range(0, 33000);
      else req = $urandom & 16'hFFFF;
      send_item(ACT_ALLOC, req, $urandom & 10'h3FF);
    end else if (sel < 90) begin
      send_item(ACT_FREE, $urandom & 16'hFFFF,
                sb.live[$urandom_range(0, sb.live.size() - 1)]);
    end else begin
      send_item(ACT_FREE, $urandom & 16'hFFFF, $urandom & 10'h3FF);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= (calm || $urandom_range(0, 99) >= 32);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_grant_index);
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // split, ignored frees, merges on each side, exact fit, no bucket, oversize
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 28, 0);
    send_item(ACT_ALLOC, 60, 0);
    send_item(ACT_FREE, 0, 1023);
    send_item(ACT_FREE, 0, 1);
    send_item(ACT_FREE, 0, 0);
    send_item(ACT_FREE, 0, 0);
    send_item(ACT_FREE, 0, 2);
    send_item(ACT_ALLOC, 32764, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 65535, 0);
    send_item(ACT_FREE, 65535, 0);
    send_item(ACT_ALLOC, 32765, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_FREE, 0, 0);
    send_item(ACT_FREE, 0, 2);
    send_item(ACT_FREE, 0, 1);

    for (int i = 0; i < 1700; i++) begin
      calm = (i >= 600 && i < 800);
      if (i == 300) hold_req = 1;
      if (i == 1000) begin
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
      end
      send_random();
      maybe_gap();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.owed.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (sb.owed.size() == 0 && sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
